@@ rtl/qro_pkg.sv @@
// ----------------------------------------------------------------------------
// qro_pkg
// shared widths for the quad / rectangle separating axis overlap test
// ----------------------------------------------------------------------------
`default_nettype none

package qro_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned NumEdges     = 4;

endpackage

`default_nettype wire

@@ rtl/qro_edge_axis.sv @@
// ----------------------------------------------------------------------------
// qro_edge_axis
// three-stage projection of both shapes onto one quad edge normal; flags
// whether that axis separates the quad and the rectangle
// ----------------------------------------------------------------------------
`default_nettype none

module qro_edge_axis #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                        clk_i,
  input  wire logic signed [CoordBits-1:0] qx_i [4],
  input  wire logic signed [CoordBits-1:0] qy_i [4],
  input  wire logic signed [CoordBits:0]   cx0_i,
  input  wire logic signed [CoordBits:0]   cx1_i,
  input  wire logic signed [CoordBits:0]   cy0_i,
  input  wire logic signed [CoordBits:0]   cy1_i,
  input  wire logic signed [CoordBits-1:0] ax_x_i,
  input  wire logic signed [CoordBits-1:0] ax_y_i,
  input  wire logic signed [CoordBits-1:0] bx_x_i,
  input  wire logic signed [CoordBits-1:0] bx_y_i,
  output logic                             sep_o
);

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned SW = PW + 1;

  // stage 1: axis components and latched points
  logic signed [DW-1:0] nx_q, ny_q;
  logic signed [CoordBits-1:0] qx_q [4];
  logic signed [CoordBits-1:0] qy_q [4];
  logic signed [DW-1:0] cx0_q, cx1_q, cy0_q, cy1_q;

  always_ff @(posedge clk_i) begin
    nx_q <= DW'(ax_y_i) - DW'(bx_y_i);
    ny_q <= DW'(bx_x_i) - DW'(ax_x_i);
    qx_q <= qx_i;
    qy_q <= qy_i;
    cx0_q <= cx0_i;
    cx1_q <= cx1_i;
    cy0_q <= cy0_i;
    cy1_q <= cy1_i;
  end

  // stage 2: products
  logic signed [PW-1:0] pqx_q [4], pqy_q [4];
  logic signed [PW-1:0] prx0_q, prx1_q, pry0_q, pry1_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      pqx_q[k] <= PW'(qx_q[k]) * PW'(nx_q);
      pqy_q[k] <= PW'(qy_q[k]) * PW'(ny_q);
    end
    prx0_q <= PW'(cx0_q) * PW'(nx_q);
    prx1_q <= PW'(cx1_q) * PW'(nx_q);
    pry0_q <= PW'(cy0_q) * PW'(ny_q);
    pry1_q <= PW'(cy1_q) * PW'(ny_q);
  end

  // stage 3: dot products and min/max; the compare below is combinational
  logic signed [SW-1:0] dq_q [4];
  logic signed [SW-1:0] rmin_q, rmax_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      dq_q[k] <= SW'(pqx_q[k]) + SW'(pqy_q[k]);
    end
    rmin_q <= ((prx0_q < prx1_q) ? SW'(prx0_q) : SW'(prx1_q))
            + ((pry0_q < pry1_q) ? SW'(pry0_q) : SW'(pry1_q));
    rmax_q <= ((prx0_q > prx1_q) ? SW'(prx0_q) : SW'(prx1_q))
            + ((pry0_q > pry1_q) ? SW'(pry0_q) : SW'(pry1_q));
  end

  // separating iff every quad point lies above rmax or every one below rmin
  logic [3:0] above, below;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      above[k] = dq_q[k] > rmax_q;
      below[k] = dq_q[k] < rmin_q;
    end
  end

  assign sep_o = (&above) | (&below);

endmodule

`default_nettype wire

@@ rtl/qro_box_axis.sv @@
// ----------------------------------------------------------------------------
// qro_box_axis
// x and y axis test, bounding box of the quad against the rectangle,
// matched to the edge-axis pipeline depth
// ----------------------------------------------------------------------------
`default_nettype none

module qro_box_axis #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                        clk_i,
  input  wire logic signed [CoordBits-1:0] qx_i [4],
  input  wire logic signed [CoordBits-1:0] qy_i [4],
  input  wire logic signed [CoordBits:0]   cx0_i,
  input  wire logic signed [CoordBits:0]   cx1_i,
  input  wire logic signed [CoordBits:0]   cy0_i,
  input  wire logic signed [CoordBits:0]   cy1_i,
  output logic                             sep_o
);

  logic [3:0] sx_q, sy_q;
  logic [1:0] s2_q, s3_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sx_q[k] <= ($signed({qx_i[k][CoordBits-1], qx_i[k]}) < cx0_i);
      sy_q[k] <= ($signed({qy_i[k][CoordBits-1], qy_i[k]}) < cy0_i);
    end
    s2_q <= {(&sx_q), (&sy_q)};
    s3_q <= s2_q;
  end

  // upper side checks
  logic [3:0] ux_q, uy_q;
  logic [1:0] u2_q, u3_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      ux_q[k] <= ($signed({qx_i[k][CoordBits-1], qx_i[k]}) > cx1_i);
      uy_q[k] <= ($signed({qy_i[k][CoordBits-1], qy_i[k]}) > cy1_i);
    end
    u2_q <= {(&ux_q), (&uy_q)};
    u3_q <= u2_q;
  end

  assign sep_o = s3_q[1] | s3_q[0] | u3_q[1] | u3_q[0];

endmodule

`default_nettype wire

@@ rtl/quad_rect_overlap_test.sv @@
// ----------------------------------------------------------------------------
// quad_rect_overlap_test
// separating axis overlap test of a convex quad against an axis-aligned
// rectangle: the normal of each quad edge and the x and y axes tested in parallel
// done_o is start delayed through vld_q and done_q, in step with overlap_o
// throughput: one beat per cycle, busy is always low
// reset clears the valid pipeline only; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module quad_rect_overlap_test #(
  parameter int unsigned CoordBits = qro_pkg::CoordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [CoordBits-1:0] v0_x_i,
  input  wire logic signed [CoordBits-1:0] v0_y_i,
  input  wire logic signed [CoordBits-1:0] v1_x_i,
  input  wire logic signed [CoordBits-1:0] v1_y_i,
  input  wire logic signed [CoordBits-1:0] v2_x_i,
  input  wire logic signed [CoordBits-1:0] v2_y_i,
  input  wire logic signed [CoordBits-1:0] v3_x_i,
  input  wire logic signed [CoordBits-1:0] v3_y_i,
  input  wire logic signed [CoordBits-1:0] rect_x_i,
  input  wire logic signed [CoordBits-1:0] rect_y_i,
  input  wire logic        [CoordBits-2:0] rect_w_i,
  input  wire logic        [CoordBits-2:0] rect_h_i,
  output logic                             done_o,
  output logic                             overlap_o
);

  import qro_pkg::*;

  localparam int unsigned Depth = 4;

  logic signed [CoordBits-1:0] qx [4];
  logic signed [CoordBits-1:0] qy [4];
  logic signed [CoordBits:0]   cx0, cx1, cy0, cy1;

  assign qx = '{v0_x_i, v1_x_i, v2_x_i, v3_x_i};
  assign qy = '{v0_y_i, v1_y_i, v2_y_i, v3_y_i};
  assign cx0 = {rect_x_i[CoordBits-1], rect_x_i};
  assign cy0 = {rect_y_i[CoordBits-1], rect_y_i};
  assign cx1 = cx0 + $signed({2'b00, rect_w_i});
  assign cy1 = cy0 + $signed({2'b00, rect_h_i});

  logic [NumEdges-1:0] esep;
  logic                bsep;

  for (genvar e = 0; e < NumEdges; e++) begin : g_edge
    qro_edge_axis #(.CoordBits(CoordBits)) u_edge (
      .clk_i  (clk_i),
      .qx_i   (qx),
      .qy_i   (qy),
      .cx0_i  (cx0),
      .cx1_i  (cx1),
      .cy0_i  (cy0),
      .cy1_i  (cy1),
      .ax_x_i (qx[e]),
      .ax_y_i (qy[e]),
      .bx_x_i (qx[(e + 1) % NumEdges]),
      .bx_y_i (qy[(e + 1) % NumEdges]),
      .sep_o  (esep[e])
    );
  end

  qro_box_axis #(.CoordBits(CoordBits)) u_box (
    .clk_i (clk_i),
    .qx_i  (qx),
    .qy_i  (qy),
    .cx0_i (cx0),
    .cx1_i (cx1),
    .cy0_i (cy0),
    .cy1_i (cy1),
    .sep_o (bsep)
  );

  logic [Depth-2:0] vld_q;
  logic             done_q, ovl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[Depth-3:0], start};
      done_q <= vld_q[Depth-2];
    end
  end

  always_ff @(posedge clk_i) begin
    ovl_q <= ~(|esep | bsep);
  end

  assign busy      = 1'b0;
  assign done_o    = done_q;
  assign overlap_o = ovl_q;

endmodule

`default_nettype wire

@@ rtl/qro_checker.sv @@
// ----------------------------------------------------------------------------
// qro_checker
// port-level checks on the overlap test
// ----------------------------------------------------------------------------
`default_nettype none

module qro_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 done_o) else $error("missing done");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(start, 4)) else $error("spurious done");

endmodule

bind quad_rect_overlap_test qro_checker u_qro_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

`default_nettype wire
